// ----- rtl/spr_pkg.sv -----
package spr_pkg;

   localparam int DEF_TIME_WIDTH   = 48;
   localparam int DEF_MAX_REQUEST  = 1023;

   localparam int INTERVAL_WIDTH   = 32;
   localparam int CAP_WIDTH        = 16;
   localparam int COUNT_WIDTH      = 10;
   localparam int TIMEOUT_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam int US_PER_MS        = 1000;
   localparam int TMO_US_WIDTH     = TIMEOUT_WIDTH + 10;
   localparam int PROD_WIDTH       = COUNT_WIDTH + INTERVAL_WIDTH;

   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = INTERVAL_WIDTH'(1000);
   localparam logic [CAP_WIDTH-1:0]      CAP_RESET      = CAP_WIDTH'(1);

   typedef enum logic [1:0] {
      STATUS_GRANT   = 2'd0,
      STATUS_REJECT  = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PERMIT_INTERVAL = 2'd0,
      CSR_MAX_STORED      = 2'd1
   } csr_index_type;

endpackage

// ----- rtl/spr_div.sv -----
module spr_div #(
   parameter int TIME_WIDTH = spr_pkg::DEF_TIME_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [TIME_WIDTH-1:0]              dividend,
   input  logic [spr_pkg::INTERVAL_WIDTH-1:0] divisor,
   output logic                               done,
   output logic [TIME_WIDTH-1:0]              quotient
);
   import spr_pkg::*;

   localparam int CW = $clog2(TIME_WIDTH + 1);

   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [INTERVAL_WIDTH-1:0] rem_ff, rem_in;
   logic [TIME_WIDTH-1:0]     quo_ff, quo_in;
   logic [INTERVAL_WIDTH:0]   trial;
   logic [INTERVAL_WIDTH:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[TIME_WIDTH-1]};
      diff    = trial - {1'b0, divisor};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(TIME_WIDTH);
         rem_in = '0;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[INTERVAL_WIDTH-1:0];
            quo_in = {quo_ff[TIME_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[INTERVAL_WIDTH-1:0];
            quo_in = {quo_ff[TIME_WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/smooth_permit_rate_limiter.sv -----
// Token bucket rate limiter with integer timing. Each request (blocking acquire or
// try-acquire with a millisecond timeout) refills the permit store from the time
// elapsed since the next-free time, takes its permits and returns the wait in
// microseconds; a late try-acquire is rejected and a zero count, a count above
// MAX_REQUEST or a zero try-acquire timeout is flagged invalid, both leaving the
// state untouched. One request at a time: req_stall stays high from the accepting
// edge until the result is loaded into the output register; a request that
// refills waits on the one-bit-per-cycle restoring divider that computes elapsed
// time over the permit interval, while invalid requests, rejected requests and
// grants without a refill skip it. The output register lets
// the next request enter while a result waits on rsp_stall. Configuration writes
// are always ready and must only be issued while no request is in flight.
module smooth_permit_rate_limiter #(
   parameter int TIME_WIDTH  = spr_pkg::DEF_TIME_WIDTH,
   parameter int MAX_REQUEST = spr_pkg::DEF_MAX_REQUEST
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [TIME_WIDTH-1:0]               req_now_us,
   input  logic [spr_pkg::COUNT_WIDTH-1:0]     req_permit_count,
   input  logic [spr_pkg::TIMEOUT_WIDTH-1:0]   req_timeout_ms,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output spr_pkg::status_type                 rsp_status,
   output logic [TIME_WIDTH-1:0]               rsp_wait_us,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [spr_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import spr_pkg::*;

   localparam int EW = (TIME_WIDTH > PROD_WIDTH) ? TIME_WIDTH : PROD_WIDTH;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_CHECK   = 9'b000000010,
      ST_COMPARE = 9'b000000100,
      ST_DIVIDE  = 9'b000001000,
      ST_REFILL  = 9'b000010000,
      ST_TAKE    = 9'b000100000,
      ST_MULT    = 9'b001000000,
      ST_FINISH  = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      type_ff, type_in;
   logic [TIME_WIDTH-1:0]     now_ff, now_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [TMO_US_WIDTH-1:0]   tmo_us_ff, tmo_us_in;
   logic [TIME_WIDTH-1:0]     deadline_ff, deadline_in;
   logic                      refill_ff, refill_in;
   logic [CAP_WIDTH-1:0]      avail_ff, avail_in;
   logic [COUNT_WIDTH-1:0]    short_ff, short_in;
   logic [PROD_WIDTH-1:0]     prod_ff, prod_in;
   logic [INTERVAL_WIDTH-1:0] interval_ff, interval_in;
   logic [CAP_WIDTH-1:0]      cap_ff, cap_in;
   logic [CAP_WIDTH-1:0]      stored_ff, stored_in;
   logic [TIME_WIDTH-1:0]     next_free_ff, next_free_in;
   status_type                res_status_ff, res_status_in;
   logic [TIME_WIDTH-1:0]     res_wait_ff, res_wait_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [TIME_WIDTH-1:0]     rsp_wait_ff, rsp_wait_in;

   logic                      req_transfer;
   logic                      rsp_transfer;
   logic [INTERVAL_WIDTH-1:0] interval_eff;
   logic                      div_start;
   logic                      div_done;
   logic [TIME_WIDTH-1:0]     div_quotient;
   logic [TIME_WIDTH:0]       deadline_sum;
   logic [TIME_WIDTH:0]       free_sum;
   logic [CAP_WIDTH:0]        refill_sum;
   logic [EW-1:0]             prod_ext;
   logic [TIME_WIDTH-1:0]     wait_sat;
   logic                      invalid;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_transfer = req_valid && !req_stall;
   assign rsp_transfer = rsp_valid_ff && !rsp_stall;
   assign interval_eff = (interval_ff == '0) ? INTERVAL_WIDTH'(1) : interval_ff;
   assign csr_ready    = 1'b1;

   spr_div #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (now_ff - next_free_ff),
      .divisor  (interval_eff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      tmo_us_in     = tmo_us_ff;
      deadline_in   = deadline_ff;
      refill_in     = refill_ff;
      avail_in      = avail_ff;
      short_in      = short_ff;
      prod_in       = prod_ff;
      interval_in   = interval_ff;
      cap_in        = cap_ff;
      stored_in     = stored_ff;
      next_free_in  = next_free_ff;
      res_status_in = res_status_ff;
      res_wait_in   = res_wait_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_wait_in   = rsp_wait_ff;
      div_start     = 1'b0;

      invalid      = (count_ff == '0) ||
                     (CAP_WIDTH'(count_ff) > CAP_WIDTH'(MAX_REQUEST)) ||
                     (type_ff && (tmo_us_ff == '0));
      deadline_sum = {1'b0, now_ff} + (TIME_WIDTH + 1)'(tmo_us_ff);
      refill_sum   = {1'b0, stored_ff} + {1'b0, div_quotient[CAP_WIDTH-1:0]};
      prod_ext     = EW'(prod_ff);
      wait_sat     = (prod_ext > EW'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}}
                                                           : prod_ext[TIME_WIDTH-1:0];
      free_sum     = {1'b0, now_ff} + {1'b0, wait_sat};

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PERMIT_INTERVAL: interval_in = csr_data[INTERVAL_WIDTH-1:0];
            CSR_MAX_STORED:      cap_in      = csr_data[CAP_WIDTH-1:0];
            default: ;
         endcase
      end

      if (rsp_transfer) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               type_in   = req_type;
               now_in    = req_now_us;
               count_in  = req_permit_count;
               tmo_us_in = TMO_US_WIDTH'(req_timeout_ms) * TMO_US_WIDTH'(US_PER_MS);
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            deadline_in = deadline_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}}
                                                   : deadline_sum[TIME_WIDTH-1:0];
            if (invalid) begin
               res_status_in = STATUS_INVALID;
               res_wait_in   = '0;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            priority if (type_ff && (next_free_ff > deadline_ff)) begin
               res_status_in = STATUS_REJECT;
               res_wait_in   = '0;
               state_in      = ST_DONE;
            end else if (now_ff >= next_free_ff) begin
               refill_in = 1'b1;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               refill_in = 1'b0;
               state_in  = ST_REFILL;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_REFILL;
            end
         end
         ST_REFILL: begin
            priority if (!refill_ff) begin
               avail_in = stored_ff;
            end else if (div_quotient > TIME_WIDTH'(cap_ff)) begin
               avail_in = cap_ff;
            end else if (refill_sum < {1'b0, cap_ff}) begin
               avail_in = refill_sum[CAP_WIDTH-1:0];
            end else begin
               avail_in = cap_ff;
            end
            state_in = ST_TAKE;
         end
         ST_TAKE: begin
            if (CAP_WIDTH'(count_ff) > avail_ff) begin
               short_in  = count_ff - avail_ff[COUNT_WIDTH-1:0];
               stored_in = '0;
            end else begin
               short_in  = '0;
               stored_in = avail_ff - CAP_WIDTH'(count_ff);
            end
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in  = PROD_WIDTH'(short_ff) * PROD_WIDTH'(interval_eff);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            next_free_in  = free_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}}
                                                 : free_sum[TIME_WIDTH-1:0];
            res_status_in = STATUS_GRANT;
            res_wait_in   = wait_sat;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_transfer) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_wait_in   = res_wait_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         cap_ff       <= CAP_RESET;
         stored_ff    <= '0;
         next_free_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff  <= interval_in;
         cap_ff       <= cap_in;
         stored_ff    <= stored_in;
         next_free_ff <= next_free_in;
      end
      type_ff       <= type_in;
      now_ff        <= now_in;
      count_ff      <= count_in;
      tmo_us_ff     <= tmo_us_in;
      deadline_ff   <= deadline_in;
      refill_ff     <= refill_in;
      avail_ff      <= avail_in;
      short_ff      <= short_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_wait_ff   <= res_wait_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wait_ff   <= rsp_wait_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_wait_us = rsp_wait_ff;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import spr_pkg::*;

   localparam int TW = DEF_TIME_WIDTH;
   localparam logic [TW-1:0] TIME_ALL = '1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      status_type      status;
      logic [TW-1:0]   wait_us;
   } permit_outcome_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_stall;
   logic                      req_type;
   logic [TW-1:0]             req_now_us;
   logic [COUNT_WIDTH-1:0]    req_permit_count;
   logic [TIMEOUT_WIDTH-1:0]  req_timeout_ms;

   logic                      rsp_valid;
   logic                      rsp_stall;
   status_type                rsp_status;
   logic [TW-1:0]             rsp_wait_us;

   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_data;

   logic [INTERVAL_WIDTH-1:0] rate_interval;
   logic [CAP_WIDTH-1:0]      rate_cap;
   logic [CAP_WIDTH-1:0]      permit_store;
   logic [TW-1:0]             next_free_us;

   permit_outcome_type outcomes_due[$];
   longint unsigned last_now = 0;
   int idle_max = 14;
   int mismatches = 0;
   int cycle_count = 0;
   int granted = 0;
   int rejected = 0;
   int invalid = 0;
   int settings_run = 0;

   smooth_permit_rate_limiter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_now_us       (req_now_us),
      .req_permit_count (req_permit_count),
      .req_timeout_ms   (req_timeout_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_wait_us      (rsp_wait_us),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, outcomes_due.size());
         $display("testbench failed");
         $finish;
      end
   end

   function automatic int draw_idle();
      if (idle_max == 0 || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, idle_max);
   endfunction

   function automatic logic [TW-1:0] time_sum(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'(TIME_ALL)) ? TIME_ALL : s[TW-1:0];
   endfunction

   function automatic longint unsigned segment_start(int seg);
      return (64'(seg) << 45) + ((64'($urandom) << 12) | 64'($urandom_range(0, 4095)));
   endfunction

   function automatic permit_outcome_type predict_permit(logic typ, logic [TW-1:0] now,
                                                         logic [COUNT_WIDTH-1:0] cnt,
                                                         logic [TIMEOUT_WIDTH-1:0] tmo);
      permit_outcome_type res;
      longint unsigned ivl, have, earned, total, missing, delay;
      res.status = STATUS_GRANT;
      res.wait_us = '0;
      ivl = (rate_interval == 0) ? 64'd1 : 64'(rate_interval);
      if (cnt == 0 || cnt > DEF_MAX_REQUEST || (typ && tmo == 0)) begin
         res.status = STATUS_INVALID;
      end else if (typ && next_free_us > time_sum(64'(now), 64'(tmo) * US_PER_MS)) begin
         res.status = STATUS_REJECT;
      end else begin
         have = 64'(permit_store);
         if (now >= next_free_us) begin
            earned = 64'(now - next_free_us) / ivl;
            total = (earned > 64'(rate_cap)) ? 64'(rate_cap) + 1 : have + earned;
            have = (total < 64'(rate_cap)) ? total : 64'(rate_cap);
         end
         if (64'(cnt) > have) begin
            missing = 64'(cnt) - have;
            have = 0;
         end else begin
            missing = 0;
            have = have - 64'(cnt);
         end
         permit_store = have[CAP_WIDTH-1:0];
         delay = missing * ivl;
         res.wait_us = (delay > 64'(TIME_ALL)) ? TIME_ALL : delay[TW-1:0];
         next_free_us = time_sum(64'(now), delay);
      end
      return res;
   endfunction

   task automatic send_request(logic typ, logic [TW-1:0] now, logic [COUNT_WIDTH-1:0] cnt,
                               logic [TIMEOUT_WIDTH-1:0] tmo);
      int gap;
      permit_outcome_type due;
      gap = draw_idle();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_now_us <= now;
      req_permit_count <= cnt;
      req_timeout_ms <= tmo;
      do @(posedge clock); while (req_stall);
      last_now = 64'(now);
      due = predict_permit(typ, now, cnt, tmo);
      outcomes_due.push_back(due);
      case (due.status)
         STATUS_GRANT: granted++;
         STATUS_REJECT: rejected++;
         default: invalid++;
      endcase
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_rate(logic [INTERVAL_WIDTH-1:0] ivl, logic [CAP_WIDTH-1:0] cap);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_PERMIT_INTERVAL;
      csr_data <= CSR_DATA_WIDTH'(ivl);
      do @(posedge clock); while (!csr_ready);
      rate_interval = ivl;
      @(negedge clock);
      csr_index <= CSR_MAX_STORED;
      csr_data <= CSR_DATA_WIDTH'(cap);
      do @(posedge clock); while (!csr_ready);
      rate_cap = cap;
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   task automatic test_invalid_requests();
      send_request(1'b0, '0, '0, '0);
      send_request(1'b1, '0, '0, 16'd5);
      send_request(1'b1, 48'd100, 10'd4, '0);
      send_request(1'b1, 48'd100, '0, '0);
   endtask

   task automatic test_default_rate();
      send_request(1'b0, '0, 10'd1, '0);
      send_request(1'b0, '0, 10'd1023, '0);
      send_request(1'b1, 48'd500, 10'd1, 16'd1);
      send_request(1'b1, 48'd500, 10'd1, '1);
      send_request(1'b0, 48'd10_000_000, 10'd1, '1);
      send_request(1'b0, 48'd10_000_000, 10'd1, '0);
      send_request(1'b1, 48'd10_000_000, 10'd2, 16'd1);
      send_request(1'b1, 48'd10_000_999, 10'd1, 16'd1);
   endtask

   task automatic test_register_extremes();
      longint unsigned t;
      t = 64'd20_000_000;
      program_rate('0, '0);
      send_request(1'b0, t[TW-1:0], 10'd1, '0);
      send_request(1'b0, TW'(t + 5), 10'd3, '0);
      program_rate('1, '1);
      send_request(1'b0, TW'(t + 100), 10'd1023, '0);
      send_request(1'b1, TW'(t + 100), 10'd1, '1);
      program_rate(32'd1, '1);
      t = 64'(next_free_us) + 100000;
      send_request(1'b0, t[TW-1:0], 10'd1, '0);
      send_request(1'b0, t[TW-1:0], 10'd1023, '0);
      program_rate(32'd1, 16'd3);
      send_request(1'b0, t[TW-1:0], 10'd2, '0);
      send_request(1'b0, t[TW-1:0], 10'd2, '0);
   endtask

   task automatic test_time_saturation();
      program_rate('1, 16'd2);
      send_request(1'b0, TIME_ALL - 1000, 10'd1023, '0);
      send_request(1'b1, TIME_ALL - 5, 10'd1, '1);
      send_request(1'b0, TIME_ALL, 10'd2, '0);
      send_request(1'b1, TIME_ALL, 10'd1, 16'd1);
   endtask

   task automatic test_random_traffic(int items, logic [INTERVAL_WIDTH-1:0] ivl,
                                      logic [CAP_WIDTH-1:0] cap, int idle,
                                      longint unsigned floor_us);
      logic typ;
      logic [COUNT_WIDTH-1:0] cnt;
      logic [TIMEOUT_WIDTH-1:0] tmo;
      longint unsigned now, unit, ahead, step, lead, pick;
      int r;
      program_rate(ivl, cap);
      idle_max = idle;
      now = (last_now > floor_us) ? last_now : floor_us;
      unit = (ivl == 0) ? 64'd1 : 64'(ivl);
      for (int i = 0; i < items; i++) begin
         ahead = (64'(next_free_us) > now) ? 64'(next_free_us) - now : 0;
         case ($urandom_range(0, 9))
            0: step = 0;
            1, 2: step = unit * $urandom_range(0, 2) + $urandom_range(0, 3);
            3, 4, 5: step = ahead + unit * $urandom_range(0, 3);
            6, 7: step = ahead / $urandom_range(1, 4);
            8: step = unit * $urandom_range(0, 40);
            default: step = 64'($urandom);
         endcase
         now = 64'(time_sum(now, step));
         typ = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 19);
         if (r == 0)
            cnt = '0;
         else if (r == 1)
            cnt = 10'd1023;
         else if (r < 6)
            cnt = COUNT_WIDTH'($urandom_range(1, 1023));
         else
            cnt = COUNT_WIDTH'($urandom_range(1, 8));
         r = $urandom_range(0, 19);
         if (r == 0) begin
            tmo = '0;
         end else if (r < 9) begin
            lead = (64'(next_free_us) > now) ? 64'(next_free_us) - now : 0;
            pick = lead / US_PER_MS + $urandom_range(0, 2);
            if (pick > 1)
               pick = pick - 1;
            if (pick > 65535)
               pick = 65535;
            tmo = (pick == 0) ? 16'd1 : pick[TIMEOUT_WIDTH-1:0];
         end else if (r < 13) begin
            tmo = TIMEOUT_WIDTH'($urandom_range(1, 10));
         end else begin
            tmo = TIMEOUT_WIDTH'($urandom_range(1, 65535));
         end
         send_request(typ, now[TW-1:0], cnt, tmo);
      end
   endtask

   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = draw_idle();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      permit_outcome_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing outstanding: status %0d wait_us %0d",
                     $time, rsp_status, rsp_wait_us);
         end else begin
            due = outcomes_due.pop_front();
            if (rsp_status !== due.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d",
                        $time, due.status, rsp_status);
            end
            if (rsp_wait_us !== due.wait_us) begin
               mismatches++;
               $display("%0t: wait_us expected %0d actual %0d",
                        $time, due.wait_us, rsp_wait_us);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = 1'b0;
      req_now_us = '0;
      req_permit_count = '0;
      req_timeout_ms = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PERMIT_INTERVAL;
      csr_data = '0;
      rate_interval = INTERVAL_RESET;
      rate_cap = CAP_RESET;
      permit_store = '0;
      next_free_us = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_invalid_requests();
      test_default_rate();
      test_register_extremes();
      test_random_traffic(100, 32'd1000, 16'd1, 14, segment_start(0));
      test_random_traffic(100, 32'd1, '1, 0, segment_start(1));
      test_random_traffic(100, '0, '0, 14, segment_start(2));
      test_random_traffic(100, INTERVAL_WIDTH'($urandom_range(1, 5000)),
                          CAP_WIDTH'($urandom_range(1, 64)), 14, segment_start(3));
      test_random_traffic(100, '1, CAP_WIDTH'($urandom_range(0, 65535)), 0,
                          segment_start(4));
      test_random_traffic(100, $urandom, CAP_WIDTH'($urandom_range(0, 65535)), 14,
                          segment_start(5));
      test_random_traffic(100, 32'd250, 16'd16, 14, segment_start(6));
      test_time_saturation();
      wait_for_results();

      $display("Checked %0d requests: %0d granted, %0d rejected, %0d invalid,",
               granted + rejected + invalid, granted, rejected, invalid);
      $display("over %0d rate settings including zero and all-ones registers,", settings_run);
      $display("with time stamps running up to saturation.");
      if (mismatches == 0 && outcomes_due.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
